FILE: rtl/chaf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chaf_pkg
// Types, widths and arithmetic helpers for the cosine-harmonic angle force.
// ---------------------------------------------------------------------------
package chaf_pkg;

  localparam int VEC_W  = 32;  // Q8.24 bond vector component
  localparam int PAR_W  = 32;  // K (Q16.16) and c0 (Q2.30)
  localparam int OUT_W  = 48;  // Q24.24 force and energy
  localparam int SQ_STG = 32;  // one root bit per stage
  localparam int UQW    = 31;  // unit vector quotient bits
  localparam int UDW    = 62;  // unit vector dividend bits
  localparam int FQW    = 48;  // force quotient bits
  localparam int FDW    = 96;  // force dividend bits
  localparam int FVW    = 60;  // force divisor bits (length << 28)

  localparam logic signed [31:0] ONE30 = 32'sh4000_0000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_LEN = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [31:0]      kf;
    logic [31:0]      c0;
    logic             zero;
  } vec_side_t;

  typedef struct packed {
    logic [5:0]  neg;
    logic [31:0] da;
    logic [31:0] db;
    logic [31:0] kf;
    logic [31:0] c0;
    logic        zero;
  } unit_side_t;

  typedef struct packed {
    logic [31:0] kf;
    logic [31:0] c0;
    logic [31:0] da;
    logic [31:0] db;
    logic        zero;
  } dp_side_t;

  typedef struct packed {
    logic [5:0]  neg;
    logic [47:0] e;
    logic        zero;
  } frc_side_t;

  function automatic logic signed [63:0] smul32(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
    logic signed [63:0] xe;
    logic signed [63:0] ye;
    xe = 64'(x);
    ye = 64'(y);
    return xe * ye;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // round(v / 2^30), half away from zero
  function automatic logic signed [63:0] srnd30(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? (~v + 64'd1) : v;
    r = (m + 64'h2000_0000) >> 30;
    return v[63] ? $signed(~r + 64'd1) : $signed(r);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/chaf_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chaf_in_if / chaf_out_if
// Valid/ready channels for angle terms in and force results out.
// ---------------------------------------------------------------------------
interface chaf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] bond_a_x;
  logic signed [31:0] bond_a_y;
  logic signed [31:0] bond_a_z;
  logic signed [31:0] bond_b_x;
  logic signed [31:0] bond_b_y;
  logic signed [31:0] bond_b_z;
  logic        [31:0] k_force;
  logic signed [31:0] cos_ref;

  modport source (output valid, bond_a_x, bond_a_y, bond_a_z, bond_b_x, bond_b_y,
                  bond_b_z, k_force, cos_ref, input ready);
  modport sink   (input valid, bond_a_x, bond_a_y, bond_a_z, bond_b_x, bond_b_y,
                  bond_b_z, k_force, cos_ref, output ready);
endinterface

interface chaf_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] force_a_x;
  logic signed [47:0] force_a_y;
  logic signed [47:0] force_a_z;
  logic signed [47:0] force_c_x;
  logic signed [47:0] force_c_y;
  logic signed [47:0] force_c_z;
  logic signed [47:0] force_b_x;
  logic signed [47:0] force_b_y;
  logic signed [47:0] force_b_z;
  logic        [47:0] bend_energy;
  logic        [1:0]  status;

  modport source (output valid, force_a_x, force_a_y, force_a_z, force_c_x, force_c_y,
                  force_c_z, force_b_x, force_b_y, force_b_z, bend_energy, status,
                  input ready);
  modport sink   (input valid, force_a_x, force_a_y, force_a_z, force_c_x, force_c_y,
                  force_c_z, force_b_x, force_b_y, force_b_z, bend_energy, status,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/chaf_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chaf_div
// Pipelined restoring divider, one quotient bit per stage.
// ovf flags a quotient that does not fit in QW bits. Needs DW-QW <= VW.
// ---------------------------------------------------------------------------
module chaf_div #(
  parameter int DW = 62,
  parameter int VW = 32,
  parameter int QW = 31
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [QW-1:0] quotient,
  output logic               ovf
);

  localparam int HW = DW - QW;

  logic [VW-1:0] den_r [QW+1];
  logic [VW-1:0] rem_r [QW+1];
  logic [QW-1:0] low_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];

  logic [VW-1:0] hi_ext;
  assign hi_ext = VW'(dividend[DW-1:QW]);

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= divisor;
      rem_r[0] <= hi_ext;
      low_r[0] <= dividend[QW-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= (hi_ext >= divisor);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [VW:0] rin;
    logic        take;
    assign rin  = {rem_r[k-1], low_r[k-1][QW-1]};
    assign take = (rin >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_r[k-1];
        rem_r[k] <= take ? VW'(rin - {1'b0, den_r[k-1]}) : rin[VW-1:0];
        low_r[k] <= {low_r[k-1][QW-2:0], 1'b0};
        q_r[k]   <= {q_r[k-1][QW-2:0], take};
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quotient = q_r[QW];
  assign ovf      = ovf_r[QW];

endmodule
`default_nettype wire

FILE: rtl/cosine_harmonic_angle_force_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cosine_harmonic_angle_force_top
// Throughput: one angle term per cycle unless stalled; the 49-stage force
// dividers, the 32-stage length root and the 32-stage unit vector dividers are
// fully pipelined. The pipeline stalls as a whole only when its last stage and
// the output register are both full and the output is not taken. Reset clears
// the valid bits and the output valid; data registers are not reset, no
// clearing pass.
// ---------------------------------------------------------------------------
module cosine_harmonic_angle_force_top
  import chaf_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  chaf_in_if.sink   req,
  chaf_out_if.source rsp
);

  localparam int LAT = 3 + SQ_STG + (UQW + 1) + 10 + (FQW + 1) + 2;

  logic           adv;
  logic [LAT-1:0] vld;

  assign adv       = !(vld[LAT-1] && rsp.valid && !rsp.ready);
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], req.valid};
    end
  end

  // input register
  logic signed [31:0] r0_a [3];
  logic signed [31:0] r0_b [3];
  logic        [31:0] r0_kf;
  logic signed [31:0] r0_c0;

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_a[0] <= req.bond_a_x;
      r0_a[1] <= req.bond_a_y;
      r0_a[2] <= req.bond_a_z;
      r0_b[0] <= req.bond_b_x;
      r0_b[1] <= req.bond_b_y;
      r0_b[2] <= req.bond_b_z;
      r0_kf   <= req.k_force;
      r0_c0   <= req.cos_ref;
    end
  end

  // squares, c0 clamp, zero-length detect
  logic [63:0] s1_sqa [3];
  logic [63:0] s1_sqb [3];
  vec_side_t   s1_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_sqa[i]    <= $unsigned(smul32(r0_a[i], r0_a[i]));
        s1_sqb[i]    <= $unsigned(smul32(r0_b[i], r0_b[i]));
        s1_side.a[i] <= r0_a[i];
        s1_side.b[i] <= r0_b[i];
      end
      s1_side.kf   <= r0_kf;
      if (r0_c0 > ONE30) begin
        s1_side.c0 <= ONE30;
      end else if (r0_c0 < -ONE30) begin
        s1_side.c0 <= -ONE30;
      end else begin
        s1_side.c0 <= r0_c0;
      end
      s1_side.zero <= ((r0_a[0] | r0_a[1] | r0_a[2]) == '0) ||
                      ((r0_b[0] | r0_b[1] | r0_b[2]) == '0);
    end
  end

  // squared lengths
  logic [63:0] s2_s [2];
  vec_side_t   s2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_s[0] <= s1_sqa[0] + s1_sqa[1] + s1_sqa[2];
      s2_s[1] <= s1_sqb[0] + s1_sqb[1] + s1_sqb[2];
      s2_side <= s1_side;
    end
  end

  // integer square root, one result bit per stage
  logic [33:0] sq_rem  [2][SQ_STG];
  logic [31:0] sq_root [2][SQ_STG];
  logic [63:0] sq_rad  [2][SQ_STG];
  vec_side_t   sq_dl   [SQ_STG];

  for (genvar j = 0; j < 2; j++) begin : g_sqj
    for (genvar k = 0; k < SQ_STG; k++) begin : g_sqk
      logic [33:0] prem;
      logic [31:0] proot;
      logic [63:0] prad;
      logic [35:0] rin;
      logic [35:0] trial;
      if (k == 0) begin : g_first
        assign prem  = '0;
        assign proot = '0;
        assign prad  = s2_s[j];
      end else begin : g_next
        assign prem  = sq_rem[j][k-1];
        assign proot = sq_root[j][k-1];
        assign prad  = sq_rad[j][k-1];
      end
      assign rin   = {prem, prad[63:62]};
      assign trial = {2'b00, proot, 2'b01};

      always_ff @(posedge clk) begin
        if (adv) begin
          if (rin >= trial) begin
            sq_rem[j][k]  <= 34'(rin - trial);
            sq_root[j][k] <= {proot[30:0], 1'b1};
          end else begin
            sq_rem[j][k]  <= rin[33:0];
            sq_root[j][k] <= {proot[30:0], 1'b0};
          end
          sq_rad[j][k] <= {prad[61:0], 2'b00};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_dl[0] <= s2_side;
      for (int i = 1; i < SQ_STG; i++) sq_dl[i] <= sq_dl[i-1];
    end
  end

  // unit vectors: round(|v| * 2^30 / d)
  logic [31:0] len_a;
  logic [31:0] len_b;
  vec_side_t   sq_out;
  unit_side_t  u_side_in;
  unit_side_t  u_dl [UQW+1];
  logic [UQW-1:0] u_q [6];

  assign len_a  = sq_root[0][SQ_STG-1];
  assign len_b  = sq_root[1][SQ_STG-1];
  assign sq_out = sq_dl[SQ_STG-1];

  always_comb begin
    u_side_in.da   = len_a;
    u_side_in.db   = len_b;
    u_side_in.kf   = sq_out.kf;
    u_side_in.c0   = sq_out.c0;
    u_side_in.zero = sq_out.zero;
    for (int i = 0; i < 3; i++) begin
      u_side_in.neg[i]   = sq_out.a[i][31];
      u_side_in.neg[i+3] = sq_out.b[i][31];
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_udiv
    logic [31:0]    comp;
    logic [31:0]    len;
    logic [UDW-1:0] num;
    assign comp = (j < 3) ? sq_out.a[j % 3] : sq_out.b[j % 3];
    assign len  = (j < 3) ? len_a : len_b;
    assign num  = {mag32(comp), 30'b0} + UDW'(len >> 1);

    chaf_div #(.DW(UDW), .VW(32), .QW(UQW)) u_div (
      .clk      (clk),
      .en       (adv),
      .dividend (num),
      .divisor  (len),
      .quotient (u_q[j]),
      .ovf      ()
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_dl[0] <= u_side_in;
      for (int i = 1; i <= UQW; i++) u_dl[i] <= u_dl[i-1];
    end
  end

  // dot product and cosine
  unit_side_t u_out;
  assign u_out = u_dl[UQW];

  logic signed [31:0] d1_ua [3];
  logic signed [31:0] d1_ub [3];
  dp_side_t           d1_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_ua[i] <= u_out.neg[i]   ? -$signed(32'(u_q[i]))   : $signed(32'(u_q[i]));
        d1_ub[i] <= u_out.neg[i+3] ? -$signed(32'(u_q[i+3])) : $signed(32'(u_q[i+3]));
      end
      d1_side.kf   <= u_out.kf;
      d1_side.c0   <= u_out.c0;
      d1_side.da   <= u_out.da;
      d1_side.db   <= u_out.db;
      d1_side.zero <= u_out.zero;
    end
  end

  logic signed [63:0] d2_pd [3];
  logic signed [31:0] d2_ua [3];
  logic signed [31:0] d2_ub [3];
  dp_side_t           d2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) d2_pd[i] <= smul32(d1_ua[i], d1_ub[i]);
      d2_ua   <= d1_ua;
      d2_ub   <= d1_ub;
      d2_side <= d1_side;
    end
  end

  logic signed [63:0] d3_dot;
  logic signed [31:0] d3_ua [3];
  logic signed [31:0] d3_ub [3];
  dp_side_t           d3_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      d3_dot  <= d2_pd[0] + d2_pd[1] + d2_pd[2];
      d3_ua   <= d2_ua;
      d3_ub   <= d2_ub;
      d3_side <= d2_side;
    end
  end

  logic signed [63:0] d3_c_raw;
  assign d3_c_raw = srnd30(d3_dot);

  logic signed [31:0] d4_c;
  logic signed [31:0] d4_ua [3];
  logic signed [31:0] d4_ub [3];
  dp_side_t           d4_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (d3_c_raw > 64'(ONE30)) begin
        d4_c <= ONE30;
      end else if (d3_c_raw < -64'(ONE30)) begin
        d4_c <= -ONE30;
      end else begin
        d4_c <= d3_c_raw[31:0];
      end
      d4_ua   <= d3_ua;
      d4_ub   <= d3_ub;
      d4_side <= d3_side;
    end
  end

  // deviation and force directions
  logic signed [32:0] d5_dev;
  logic signed [63:0] d5_pua [3];
  logic signed [63:0] d5_pub [3];
  logic signed [31:0] d5_ua  [3];
  logic signed [31:0] d5_ub  [3];
  dp_side_t           d5_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      d5_dev <= 33'(d4_c) - 33'($signed(d4_side.c0));
      for (int i = 0; i < 3; i++) begin
        d5_pua[i] <= smul32(d4_ua[i], d4_c);
        d5_pub[i] <= smul32(d4_ub[i], d4_c);
      end
      d5_ua   <= d4_ua;
      d5_ub   <= d4_ub;
      d5_side <= d4_side;
    end
  end

  // g[0..2] pull the first atom, g[3..5] the third
  logic signed [33:0] d6_g [6];
  logic        [31:0] d6_dm;
  logic               d6_dfneg;
  dp_side_t           d6_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d6_g[i]   <= 34'(d5_ub[i]) - 34'(srnd30(d5_pua[i]));
        d6_g[i+3] <= 34'(d5_ua[i]) - 34'(srnd30(d5_pub[i]));
      end
      d6_dm    <= d5_dev[32] ? 32'(-d5_dev) : d5_dev[31:0];
      d6_dfneg <= (d5_dev > 33'sd0);
      d6_side  <= d5_side;
    end
  end

  logic [63:0] d7_dfm;
  logic [63:0] d7_dd;
  logic [31:0] d7_gm [6];
  logic [5:0]  d7_neg;
  dp_side_t    d7_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      d7_dfm <= 64'(d6_side.kf) * 64'(d6_dm);
      d7_dd  <= 64'(d6_dm) * 64'(d6_dm);
      for (int j = 0; j < 6; j++) begin
        d7_gm[j]  <= d6_g[j][33] ? 32'(-d6_g[j]) : d6_g[j][31:0];
        d7_neg[j] <= d6_dfneg ^ d6_g[j][33];
      end
      d7_side <= d6_side;
    end
  end

  logic [32:0] d8_dev2;
  logic [63:0] d8_pl [6];
  logic [63:0] d8_ph [6];
  logic [5:0]  d8_neg;
  dp_side_t    d8_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      d8_dev2 <= 33'((d7_dd + 64'h2000_0000) >> 30);
      for (int j = 0; j < 6; j++) begin
        d8_pl[j] <= 64'(d7_dfm[31:0])  * 64'(d7_gm[j]);
        d8_ph[j] <= 64'(d7_dfm[63:32]) * 64'(d7_gm[j]);
      end
      d8_neg  <= d7_neg;
      d8_side <= d7_side;
    end
  end

  logic [FDW-1:0] d9_prod [6];
  logic [63:0]    d9_ecalc;
  logic [5:0]     d9_neg;
  dp_side_t       d9_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 6; j++) begin
        d9_prod[j] <= (FDW'(d8_ph[j]) << 32) + FDW'(d8_pl[j]);
      end
      d9_ecalc <= 64'(d8_side.kf) * 64'(d8_dev2);
      d9_neg   <= d8_neg;
      d9_side  <= d8_side;
    end
  end

  // rounding offset is half the divisor: length << 27
  logic [FDW-1:0] d10_num [6];
  frc_side_t      d10_fside;
  logic [31:0]    d10_da;
  logic [31:0]    d10_db;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 6; j++) begin
        d10_num[j] <= d9_prod[j] +
                      FDW'({(j < 3) ? d9_side.da : d9_side.db, 27'b0});
      end
      d10_fside.neg  <= d9_neg;
      d10_fside.e    <= 48'((d9_ecalc + 64'h40_0000) >> 23);
      d10_fside.zero <= d9_side.zero;
      d10_da         <= d9_side.da;
      d10_db         <= d9_side.db;
    end
  end

  // force division
  logic [FQW-1:0] f_q   [6];
  logic [5:0]     f_ovf;
  frc_side_t      f_dl  [FQW+1];

  for (genvar j = 0; j < 6; j++) begin : g_fdiv
    logic [FVW-1:0] den;
    assign den = {(j < 3) ? d10_da : d10_db, 28'b0};

    chaf_div #(.DW(FDW), .VW(FVW), .QW(FQW)) u_div (
      .clk      (clk),
      .en       (adv),
      .dividend (d10_num[j]),
      .divisor  (den),
      .quotient (f_q[j]),
      .ovf      (f_ovf[j])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_dl[0] <= d10_fside;
      for (int i = 1; i <= FQW; i++) f_dl[i] <= f_dl[i-1];
    end
  end

  // sign and saturate outer forces
  frc_side_t f_out;
  assign f_out = f_dl[FQW];

  logic signed [47:0] g1_f [6];
  logic [5:0]         g1_sat;
  logic [47:0]        g1_e;
  logic               g1_zero;

  for (genvar j = 0; j < 6; j++) begin : g_fsat
    logic [47:0] lim;
    logic        sat;
    logic [47:0] m;
    assign lim = f_out.neg[j] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    assign sat = f_ovf[j] || (f_q[j] > lim);
    assign m   = sat ? lim : f_q[j];

    always_ff @(posedge clk) begin
      if (adv) begin
        g1_f[j]   <= f_out.neg[j] ? $signed(~m + 48'd1) : $signed(m);
        g1_sat[j] <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_e    <= f_out.e;
      g1_zero <= f_out.zero;
    end
  end

  // center force = -(fa + fb)
  logic signed [47:0] g2_fa [3];
  logic signed [47:0] g2_fb [3];
  logic signed [47:0] g2_fc [3];
  logic               g2_sat;
  logic [47:0]        g2_e;
  logic               g2_zero;
  logic signed [49:0] g1_sum [3];
  logic [2:0]         g1_csat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g1_sum[i]  = -50'(g1_f[i]) - 50'(g1_f[i+3]);
      g1_csat[i] = (g1_sum[i] > 50'sh7FFF_FFFF_FFFF) || (g1_sum[i] < -50'sh8000_0000_0000);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        g2_fa[i] <= g1_f[i];
        g2_fb[i] <= g1_f[i+3];
        if (g1_sum[i] > 50'sh7FFF_FFFF_FFFF) begin
          g2_fc[i] <= 48'sh7FFF_FFFF_FFFF;
        end else if (g1_sum[i] < -50'sh8000_0000_0000) begin
          g2_fc[i] <= 48'sh8000_0000_0000;
        end else begin
          g2_fc[i] <= g1_sum[i][47:0];
        end
      end
      g2_sat  <= (|g1_sat) || (|g1_csat);
      g2_e    <= g1_e;
      g2_zero <= g1_zero;
    end
  end

  // output register
  logic ld;
  assign ld = vld[LAT-1] && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ld) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      if (g2_zero) begin
        rsp.force_a_x   <= '0;
        rsp.force_a_y   <= '0;
        rsp.force_a_z   <= '0;
        rsp.force_c_x   <= '0;
        rsp.force_c_y   <= '0;
        rsp.force_c_z   <= '0;
        rsp.force_b_x   <= '0;
        rsp.force_b_y   <= '0;
        rsp.force_b_z   <= '0;
        rsp.bend_energy <= '0;
        rsp.status      <= ST_ZERO_LEN;
      end else begin
        rsp.force_a_x   <= g2_fa[0];
        rsp.force_a_y   <= g2_fa[1];
        rsp.force_a_z   <= g2_fa[2];
        rsp.force_c_x   <= g2_fc[0];
        rsp.force_c_y   <= g2_fc[1];
        rsp.force_c_z   <= g2_fc[2];
        rsp.force_b_x   <= g2_fb[0];
        rsp.force_b_y   <= g2_fb[1];
        rsp.force_b_z   <= g2_fb[2];
        rsp.bend_energy <= g2_e;
        rsp.status      <= g2_sat ? ST_SAT : ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for cosine_harmonic_angle_force_top. Angle terms stream
// in over a valid/ready channel. A bit-exact fixed-point model of the force and
// energy math predicts each result, and the bench compares every field of every
// output transfer against it. Both channels idle in random bursts.
// ---------------------------------------------------------------------------
module testbench
  import chaf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LIMIT_CYCLES = 400000;
  localparam int  QUIET_TAIL   = 300;
  localparam int  DRAIN_CYCLES = 200;
  localparam longint F_MAX = (64'sd1 <<< 47) - 1;
  localparam longint F_MIN = -(64'sd1 <<< 47);

  typedef struct {
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic        [31:0] kf;
    logic signed [31:0] c0;
  } angle_term_t;

  typedef struct {
    logic signed [47:0] fa [3];
    logic signed [47:0] fc [3];
    logic signed [47:0] fb [3];
    logic        [47:0] energy;
    status_t            status;
  } angle_force_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  chaf_in_if  req_if ();
  chaf_out_if rsp_if ();

  cosine_harmonic_angle_force_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  angle_term_t  pending_terms [$];
  angle_force_t expected_forces [$];
  angle_term_t  term_on_bus;
  int           error_count = 0;
  int           cycle_count = 0;
  int           send_gap = 0;
  int           recv_stall = 0;
  bit           quiet = 1'b0;

  // ---- bit-exact prediction ----

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s   = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint round_shift(input longint v, input int sh);
    logic [63:0] r;
    r = (abs64(v) + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unit_q30(input longint v, input logic [63:0] d);
    logic [63:0] q;
    q = ((abs64(v) << 30) + (d >> 1)) / d;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  // quotient saturates at the limit for its sign
  function automatic longint force_q24(input logic [63:0] dfm, input bit dfneg,
                                       input longint g, input logic [63:0] d,
                                       inout bit sat);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic [127:0] lim;
    bit           neg;
    neg = dfneg != (g < 0);
    if (dfm == 0 || g == 0) return 0;
    den = 128'(d) << 28;
    num = 128'(dfm) * 128'(abs64(g)) + (den >> 1);
    q   = num / den;
    lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
    if (q > lim) begin
      q   = lim;
      sat = 1'b1;
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic angle_force_t predict_angle_force(input angle_term_t t);
    angle_force_t r;
    longint       a [3], b [3], ua [3], ub [3];
    longint       fa, fb, fc, c, c0, dev, dot, ga, gb;
    logic [63:0]  sa, sb, da, db, kf, dm, dfm, dev2, e;
    bit           sat;
    sa = 0; sb = 0; dot = 0; sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'(t.a[i]);
      b[i] = longint'(t.b[i]);
      sa   = sa + 64'(a[i] * a[i]);
      sb   = sb + 64'(b[i] * b[i]);
    end
    kf = 64'(t.kf);
    c0 = longint'(t.c0);
    if (c0 > longint'(ONE30)) c0 = longint'(ONE30);
    if (c0 < -longint'(ONE30)) c0 = -longint'(ONE30);
    if (sa == 0 || sb == 0) begin
      for (int i = 0; i < 3; i++) begin
        r.fa[i] = '0; r.fb[i] = '0; r.fc[i] = '0;
      end
      r.energy = '0;
      r.status = ST_ZERO_LEN;
      return r;
    end
    da = int_sqrt(sa);
    db = int_sqrt(sb);
    for (int i = 0; i < 3; i++) begin
      ua[i] = unit_q30(a[i], da);
      ub[i] = unit_q30(b[i], db);
      dot   = dot + ua[i] * ub[i];
    end
    c = round_shift(dot, 30);
    if (c > longint'(ONE30)) c = longint'(ONE30);
    if (c < -longint'(ONE30)) c = -longint'(ONE30);
    dev = c - c0;
    dm  = abs64(dev);
    dfm = kf * dm;
    for (int i = 0; i < 3; i++) begin
      ga = ub[i] - round_shift(ua[i] * c, 30);
      gb = ua[i] - round_shift(ub[i] * c, 30);
      fa = force_q24(dfm, dev > 0, ga, da, sat);
      fb = force_q24(dfm, dev > 0, gb, db, sat);
      fc = -fa - fb;
      if (fc > F_MAX) begin fc = F_MAX; sat = 1'b1; end
      if (fc < F_MIN) begin fc = F_MIN; sat = 1'b1; end
      r.fa[i] = fa[47:0];
      r.fb[i] = fb[47:0];
      r.fc[i] = fc[47:0];
    end
    dev2 = (dm * dm + (64'd1 << 29)) >> 30;
    e    = (kf * dev2 + (64'd1 << 22)) >> 23;
    r.energy = e[47:0];
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // ---- stimulus ----

  function automatic angle_term_t make_term(input logic signed [31:0] ax, ay, az,
                                            input logic signed [31:0] bx, by, bz,
                                            input logic [31:0] kf,
                                            input logic signed [31:0] c0);
    angle_term_t t;
    t.a[0] = ax; t.a[1] = ay; t.a[2] = az;
    t.b[0] = bx; t.b[1] = by; t.b[2] = bz;
    t.kf = kf;
    t.c0 = c0;
    return t;
  endfunction

  function automatic logic signed [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      2: return $signed($urandom_range(0, 64)) - 32'sd32;
      default: return $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    endcase
  endfunction

  function automatic angle_term_t rand_term();
    angle_term_t t;
    int          mode;
    for (int i = 0; i < 3; i++) begin
      mode = $urandom_range(0, 3);
      t.a[i] = rand_coord(mode);
      mode = $urandom_range(0, 3);
      t.b[i] = rand_coord(mode);
    end
    if ($urandom_range(0, 39) == 0) t.a = '{0, 0, 0};
    if ($urandom_range(0, 39) == 0) t.b = '{0, 0, 0};
    case ($urandom_range(0, 3))
      0:       t.kf = $urandom;
      1:       t.kf = $urandom_range(0, 32'h00FF_FFFF);
      2:       t.kf = $urandom_range(0, 32'h0000_FFFF);
      default: t.kf = $urandom_range(0, 32'h0FFF_FFFF);
    endcase
    if ($urandom_range(0, 7) == 0) t.c0 = $urandom;
    else t.c0 = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    return t;
  endfunction

  // ---- checking ----

  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // ---- driver: input channel ----

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready)
        expected_forces.push_back(predict_angle_force(term_on_bus));
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 7) - 1;
          req_if.valid <= 1'b0;
        end else if (pending_terms.size() > 0) begin
          term_on_bus = pending_terms.pop_front();
          req_if.valid    <= 1'b1;
          req_if.bond_a_x <= term_on_bus.a[0];
          req_if.bond_a_y <= term_on_bus.a[1];
          req_if.bond_a_z <= term_on_bus.a[2];
          req_if.bond_b_x <= term_on_bus.b[0];
          req_if.bond_b_y <= term_on_bus.b[1];
          req_if.bond_b_z <= term_on_bus.b[2];
          req_if.k_force  <= term_on_bus.kf;
          req_if.cos_ref  <= term_on_bus.c0;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      quiet <= pending_terms.size() < QUIET_TAIL;
    end
  end

  // ---- monitor: output channel ----

  always @(posedge clk) begin
    angle_force_t exp_r;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_forces.size() == 0) begin
          $error("result transfer with no expected result");
          error_count++;
        end else begin
          exp_r = expected_forces.pop_front();
          check_field("force_a_x", exp_r.fa[0], rsp_if.force_a_x);
          check_field("force_a_y", exp_r.fa[1], rsp_if.force_a_y);
          check_field("force_a_z", exp_r.fa[2], rsp_if.force_a_z);
          check_field("force_c_x", exp_r.fc[0], rsp_if.force_c_x);
          check_field("force_c_y", exp_r.fc[1], rsp_if.force_c_y);
          check_field("force_c_z", exp_r.fc[2], rsp_if.force_c_z);
          check_field("force_b_x", exp_r.fb[0], rsp_if.force_b_x);
          check_field("force_b_y", exp_r.fb[1], rsp_if.force_b_y);
          check_field("force_b_z", exp_r.fb[2], rsp_if.force_b_z);
          check_field("bend_energy", exp_r.energy, rsp_if.bend_energy);
          check_field("status", 48'(exp_r.status), 48'(rsp_if.status));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 7) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // ---- watchdog ----

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---- sequence ----

  initial begin
    req_if.valid    = 1'b0;
    req_if.bond_a_x = '0;
    req_if.bond_a_y = '0;
    req_if.bond_a_z = '0;
    req_if.bond_b_x = '0;
    req_if.bond_b_y = '0;
    req_if.bond_b_z = '0;
    req_if.k_force  = '0;
    req_if.cos_ref  = '0;
    rsp_if.ready    = 1'b0;

    // zero-length bonds
    pending_terms.push_back(make_term(0, 0, 0, 32'sh0100_0000, 0, 0, 32'h0010_0000, 0));
    pending_terms.push_back(make_term(32'sh0100_0000, 0, 0, 0, 0, 0, 32'h0010_0000, 0));
    pending_terms.push_back(make_term(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'sh4000_0000));
    // parallel, antiparallel, perpendicular
    pending_terms.push_back(make_term(32'sh0100_0000, 0, 0, 32'sh0200_0000, 0, 0,
                                      32'h0064_0000, 0));
    pending_terms.push_back(make_term(0, 32'sh0100_0000, 0, 0, -32'sh0100_0000, 0,
                                      32'h0064_0000, 32'sh4000_0000));
    pending_terms.push_back(make_term(0, 0, 32'sh0100_0000, 32'sh0100_0000, 0, 0,
                                      32'h0064_0000, -32'sh2000_0000));
    // zero and full force constant
    pending_terms.push_back(make_term(32'sh0080_0000, 32'sh0080_0000, 0, 0, 32'sh0100_0000,
                                      0, 32'h0000_0000, 32'sh1000_0000));
    pending_terms.push_back(make_term(32'sh0080_0000, 32'sh0080_0000, 0, 0, 32'sh0100_0000,
                                      0, 32'hFFFF_FFFF, -32'sh4000_0000));
    // extreme coordinates
    pending_terms.push_back(make_term(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                      32'hFFFF_FFFF, 32'sh4000_0000));
    pending_terms.push_back(make_term(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                      32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                      32'h8000_0000, 0));
    // reference cosine out of range, clamped
    pending_terms.push_back(make_term(32'sh0100_0000, 0, 0, 0, 32'sh0100_0000, 0,
                                      32'h0001_0000, 32'sh7FFF_FFFF));
    pending_terms.push_back(make_term(32'sh0100_0000, 0, 0, 0, 32'sh0100_0000, 0,
                                      32'h0001_0000, 32'sh8000_0000));
    // tiny bonds, big constant: saturation
    pending_terms.push_back(make_term(1, 0, 0, 0, 1, 0, 32'hFFFF_FFFF, -32'sh4000_0000));
    pending_terms.push_back(make_term(1, 1, 0, -1, 1, 0, 32'hFFFF_FFFF, 32'sh4000_0000));
    pending_terms.push_back(make_term(-1, -1, -1, 3, -2, 1, 32'h7FFF_FFFF, 0));
    pending_terms.push_back(make_term(32'sh0000_0010, 0, 0, 0, 0, -32'sh0000_0010,
                                      32'hFFFF_FFFF, 32'sh3FFF_FFFF));
    for (int i = 0; i < 2000; i++) pending_terms.push_back(rand_term());

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_terms.size() > 0 || req_if.valid || expected_forces.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
